// File: rtl/core/mecanum_wheel_speed_mixer_defines.svh
// ----------------------------------------------------------------------------
// Mecanum wheel speed mixer assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef MECANUM_WHEEL_SPEED_MIXER_DEFINES_SVH
`define MECANUM_WHEEL_SPEED_MIXER_DEFINES_SVH

// same-cycle implication
`define MWSM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MWSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/mwsm_pkg.sv
// ----------------------------------------------------------------------------
// Mecanum wheel speed mixer package
// Widths, wheel indexes and divider pipeline types.
// ----------------------------------------------------------------------------
package mwsm_pkg;

  localparam int SPEED_WIDTH = 16;
  localparam int LIMIT_WIDTH = 15;
  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = LIMIT_WIDTH'(6000);

  localparam int NUM_WHEELS = 4;
  localparam int WHEEL_FL   = 0;
  localparam int WHEEL_FR   = 1;
  localparam int WHEEL_RR   = 2;
  localparam int WHEEL_RL   = 3;

  // clamp compare width, wheel sum width, magnitude width, product and result widths
  localparam int CLAMP_W = ((SPEED_WIDTH > LIMIT_WIDTH) ? SPEED_WIDTH : LIMIT_WIDTH) + 1;
  localparam int SUM_W   = SPEED_WIDTH + 2;
  localparam int MAG_W   = SPEED_WIDTH + 1;
  localparam int PROD_W  = MAG_W + LIMIT_WIDTH;
  localparam int RES_W   = (SPEED_WIDTH > LIMIT_WIDTH) ? SPEED_WIDTH : LIMIT_WIDTH;

  typedef struct packed {
    logic [PROD_W-1:0]      rem;
    logic [LIMIT_WIDTH-1:0] quo;
    logic                   neg;
    logic [SPEED_WIDTH-1:0] pass;
  } div_lane_t;

  typedef struct packed {
    logic [MAG_W-1:0]                 divisor;
    logic                             scale;
    div_lane_t [NUM_WHEELS-1:0]       lane;
  } div_item_t;

endpackage

// File: rtl/core/mwsm_cmd_if.sv
// ----------------------------------------------------------------------------
// Motion command channel
// Forward speed, rightward speed and turn rate with valid/ready.
// ----------------------------------------------------------------------------
interface mwsm_cmd_if;
  import mwsm_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SPEED_WIDTH-1:0] x_speed;
  logic signed [SPEED_WIDTH-1:0] y_speed;
  logic signed [SPEED_WIDTH-1:0] turn_rate;

  modport source (output valid, x_speed, y_speed, turn_rate, input ready);
  modport sink   (input valid, x_speed, y_speed, turn_rate, output ready);
endinterface

// File: rtl/core/mwsm_wheel_if.sv
// ----------------------------------------------------------------------------
// Wheel speed channel
// Four normalized wheel targets with valid/ready.
// ----------------------------------------------------------------------------
interface mwsm_wheel_if;
  import mwsm_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SPEED_WIDTH-1:0] front_left_speed;
  logic signed [SPEED_WIDTH-1:0] front_right_speed;
  logic signed [SPEED_WIDTH-1:0] rear_right_speed;
  logic signed [SPEED_WIDTH-1:0] rear_left_speed;

  modport source (output valid, front_left_speed, front_right_speed, rear_right_speed,
                  rear_left_speed, input ready);
  modport sink   (input valid, front_left_speed, front_right_speed, rear_right_speed,
                  rear_left_speed, output ready);
endinterface

// File: rtl/core/mwsm_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Speed limit register write data with valid/ready.
// ----------------------------------------------------------------------------
interface mwsm_cfg_if;
  import mwsm_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [LIMIT_WIDTH-1:0] max_wheel_speed;

  modport source (output valid, max_wheel_speed, input ready);
  modport sink   (input valid, max_wheel_speed, output ready);
endinterface

// File: rtl/core/mwsm_div_stage.sv
// ----------------------------------------------------------------------------
// Divider stage
// One restoring division step for all four wheels, registered.
// ----------------------------------------------------------------------------
module mwsm_div_stage (
  input  logic                clk_i,
  input  logic                en_i,
  input  mwsm_pkg::div_item_t item_i,
  output mwsm_pkg::div_item_t item_o
);
  import mwsm_pkg::*;

  div_item_t         item_d;
  div_item_t         item_q;
  logic [PROD_W-1:0] dshift;
  logic [PROD_W:0]   diff [NUM_WHEELS];

  always_comb begin
    item_d = item_i;
    dshift = {1'b0, item_i.divisor, {(LIMIT_WIDTH-1){1'b0}}};
    for (int k = 0; k < NUM_WHEELS; k++) begin
      diff[k] = {1'b0, item_i.lane[k].rem} - {1'b0, dshift};
      if (!diff[k][PROD_W]) begin
        item_d.lane[k].rem = {diff[k][PROD_W-2:0], 1'b0};
      end else begin
        item_d.lane[k].rem = {item_i.lane[k].rem[PROD_W-2:0], 1'b0};
      end
      item_d.lane[k].quo = {item_i.lane[k].quo[LIMIT_WIDTH-2:0], ~diff[k][PROD_W]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

// File: rtl/core/mecanum_wheel_speed_mixer.sv
// ----------------------------------------------------------------------------
// Mecanum wheel speed mixer
// Clamps linear speeds, forms four wheel sums and scales them to the limit.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// cmd_i     in   x_speed, y_speed, turn_rate
// wheel_o   out  front_left, front_right, rear_right, rear_left speeds
// cfg_i     in   max_wheel_speed
//
// One item per cycle unless wheel_o stalls; the restoring divider resolves
// one quotient bit per stage.
// Stages: clamp, sums, magnitudes, peak, multiply, divide steps, output.
// A stalled output fills bubbles upstream; a full pipeline drops cmd_i.ready.
// Reset clears valid bits; the limit resets to 6000.
// ----------------------------------------------------------------------------
`include "mecanum_wheel_speed_mixer_defines.svh"

module mecanum_wheel_speed_mixer (
  input  logic          clk_i,
  input  logic          rst_ni,
  mwsm_cmd_if.sink      cmd_i,
  mwsm_wheel_if.source  wheel_o,
  mwsm_cfg_if.sink      cfg_i
);
  import mwsm_pkg::*;

  localparam int ST_CLAMP   = 0;
  localparam int ST_SUM     = 1;
  localparam int ST_MAG     = 2;
  localparam int ST_PEAK    = 3;
  localparam int ST_MUL     = 4;
  localparam int ST_DIV0    = 5;
  localparam int ST_OUT     = ST_DIV0 + LIMIT_WIDTH;
  localparam int NUM_STAGES = ST_OUT + 1;

  logic [LIMIT_WIDTH-1:0] lim_q;
  logic [NUM_STAGES-1:0]  v_q;
  logic [NUM_STAGES-1:0]  en;

  // config register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= LIMIT_RESET;
    end else if (cfg_i.valid) begin
      lim_q <= cfg_i.max_wheel_speed;
    end
  end

  // pipeline flow control
  always_comb begin
    en[NUM_STAGES-1] = !v_q[NUM_STAGES-1] || wheel_o.ready;
    for (int k = NUM_STAGES-2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= cmd_i.valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign cmd_i.ready = en[ST_CLAMP];

  // clamp
  logic signed [CLAMP_W-1:0]     lim_s;
  logic signed [CLAMP_W-1:0]     x_w;
  logic signed [CLAMP_W-1:0]     y_w;
  logic signed [SPEED_WIDTH-1:0] x_c_d;
  logic signed [SPEED_WIDTH-1:0] y_c_d;
  logic signed [SPEED_WIDTH-1:0] x_c_q;
  logic signed [SPEED_WIDTH-1:0] y_c_q;
  logic signed [SPEED_WIDTH-1:0] t_q;

  assign lim_s = signed'(CLAMP_W'(lim_q));
  assign x_w   = CLAMP_W'(cmd_i.x_speed);
  assign y_w   = CLAMP_W'(cmd_i.y_speed);

  always_comb begin
    priority if (x_w > lim_s) begin
      x_c_d = lim_s[SPEED_WIDTH-1:0];
    end else if (x_w < -lim_s) begin
      x_c_d = SPEED_WIDTH'(-lim_s);
    end else begin
      x_c_d = cmd_i.x_speed;
    end
    priority if (y_w > lim_s) begin
      y_c_d = lim_s[SPEED_WIDTH-1:0];
    end else if (y_w < -lim_s) begin
      y_c_d = SPEED_WIDTH'(-lim_s);
    end else begin
      y_c_d = cmd_i.y_speed;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_CLAMP]) begin
      x_c_q <= x_c_d;
      y_c_q <= y_c_d;
      t_q   <= cmd_i.turn_rate;
    end
  end

  // wheel sums
  logic signed [SUM_W-1:0] xs;
  logic signed [SUM_W-1:0] ys;
  logic signed [SUM_W-1:0] ts;
  logic signed [SUM_W-1:0] sum_d [NUM_WHEELS];
  logic signed [SUM_W-1:0] sum_q [NUM_WHEELS];

  assign xs = SUM_W'(x_c_q);
  assign ys = SUM_W'(y_c_q);
  assign ts = SUM_W'(t_q);

  always_comb begin
    sum_d[WHEEL_FL] =  xs + ys - ts;
    sum_d[WHEEL_FR] = -xs + ys - ts;
    sum_d[WHEEL_RR] = -xs - ys - ts;
    sum_d[WHEEL_RL] =  xs - ys - ts;
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_SUM]) begin
      sum_q <= sum_d;
    end
  end

  // magnitudes
  logic [MAG_W-1:0]       mag_q  [NUM_WHEELS];
  logic                   neg_q  [NUM_WHEELS];
  logic [SPEED_WIDTH-1:0] pass_q [NUM_WHEELS];
  logic [SUM_W-1:0]       abs_d  [NUM_WHEELS];

  always_comb begin
    for (int k = 0; k < NUM_WHEELS; k++) begin
      abs_d[k] = sum_q[k][SUM_W-1] ? SUM_W'(-sum_q[k]) : SUM_W'(sum_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_MAG]) begin
      for (int k = 0; k < NUM_WHEELS; k++) begin
        mag_q[k]  <= abs_d[k][MAG_W-1:0];
        neg_q[k]  <= sum_q[k][SUM_W-1];
        pass_q[k] <= sum_q[k][SPEED_WIDTH-1:0];
      end
    end
  end

  // peak
  logic [MAG_W-1:0]       m01;
  logic [MAG_W-1:0]       m23;
  logic [MAG_W-1:0]       peak_q;
  logic [MAG_W-1:0]       pk_mag_q  [NUM_WHEELS];
  logic                   pk_neg_q  [NUM_WHEELS];
  logic [SPEED_WIDTH-1:0] pk_pass_q [NUM_WHEELS];

  assign m01 = (mag_q[WHEEL_FL] > mag_q[WHEEL_FR]) ? mag_q[WHEEL_FL] : mag_q[WHEEL_FR];
  assign m23 = (mag_q[WHEEL_RR] > mag_q[WHEEL_RL]) ? mag_q[WHEEL_RR] : mag_q[WHEEL_RL];

  always_ff @(posedge clk_i) begin
    if (en[ST_PEAK]) begin
      peak_q    <= (m01 > m23) ? m01 : m23;
      pk_mag_q  <= mag_q;
      pk_neg_q  <= neg_q;
      pk_pass_q <= pass_q;
    end
  end

  // scale decision and dividend
  div_item_t div_s [LIMIT_WIDTH+1];
  div_item_t mul_d;
  div_item_t mul_q;

  always_comb begin
    mul_d.divisor = peak_q;
    mul_d.scale   = peak_q > lim_q;
    for (int k = 0; k < NUM_WHEELS; k++) begin
      mul_d.lane[k].rem  = PROD_W'(pk_mag_q[k]) * PROD_W'(lim_q);
      mul_d.lane[k].quo  = '0;
      mul_d.lane[k].neg  = pk_neg_q[k];
      mul_d.lane[k].pass = pk_pass_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_MUL]) begin
      mul_q <= mul_d;
    end
  end

  assign div_s[0] = mul_q;

  // divider
  for (genvar i = 0; i < LIMIT_WIDTH; i++) begin : g_div
    mwsm_div_stage u_div_stage (
      .clk_i  (clk_i),
      .en_i   (en[ST_DIV0+i]),
      .item_i (div_s[i]),
      .item_o (div_s[i+1])
    );
  end

  // output register
  logic [RES_W-1:0]       q_ext [NUM_WHEELS];
  logic [RES_W-1:0]       q_sgn [NUM_WHEELS];
  logic [SPEED_WIDTH-1:0] spd_d [NUM_WHEELS];
  logic [SPEED_WIDTH-1:0] spd_q [NUM_WHEELS];

  always_comb begin
    for (int k = 0; k < NUM_WHEELS; k++) begin
      q_ext[k] = RES_W'(div_s[LIMIT_WIDTH].lane[k].quo);
      q_sgn[k] = div_s[LIMIT_WIDTH].lane[k].neg ? RES_W'(-q_ext[k]) : q_ext[k];
      spd_d[k] = div_s[LIMIT_WIDTH].scale ? q_sgn[k][SPEED_WIDTH-1:0]
                                          : div_s[LIMIT_WIDTH].lane[k].pass;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) begin
      spd_q <= spd_d;
    end
  end

  assign wheel_o.valid             = v_q[ST_OUT];
  assign wheel_o.front_left_speed  = spd_q[WHEEL_FL];
  assign wheel_o.front_right_speed = spd_q[WHEEL_FR];
  assign wheel_o.rear_right_speed  = spd_q[WHEEL_RR];
  assign wheel_o.rear_left_speed   = spd_q[WHEEL_RL];

  // assertions
  logic x_in_lim;
  logic y_in_lim;

  assign x_in_lim = (CLAMP_W'(x_c_q) <= lim_s) && (CLAMP_W'(x_c_q) >= -lim_s);
  assign y_in_lim = (CLAMP_W'(y_c_q) <= lim_s) && (CLAMP_W'(y_c_q) >= -lim_s);

  `MWSM_ASSERT_IMPL(a_clamp_x, v_q[ST_CLAMP], x_in_lim, "clamped x out of range")
  `MWSM_ASSERT_IMPL(a_clamp_y, v_q[ST_CLAMP], y_in_lim, "clamped y out of range")

  for (genvar k = 0; k < NUM_WHEELS; k++) begin : g_chk
    logic quo_ok;
    assign quo_ok = !div_s[LIMIT_WIDTH].scale || (div_s[LIMIT_WIDTH].lane[k].quo <= lim_q);
    `MWSM_ASSERT_IMPL(a_peak_max, v_q[ST_PEAK], peak_q >= pk_mag_q[k], "peak below a wheel")
    `MWSM_ASSERT_IMPL(a_quo_lim, v_q[ST_OUT-1], quo_ok, "scaled wheel exceeds limit")
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Mecanum wheel speed mixer testbench
// Drives motion commands under random source and sink stalls, rewrites the
// speed limit between drained phases, and checks each wheel transfer against
// a clamp, mix and scale predictor kept in a small scoreboard.
// ----------------------------------------------------------------------------
module tb;
  import mwsm_pkg::*;

  localparam int PIPE_LATENCY = 6 + LIMIT_WIDTH;
  localparam int LONG_HOLD    = 80;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 120;

  typedef logic signed [SPEED_WIDTH-1:0]             speed_t;
  typedef logic [NUM_WHEELS-1:0][SPEED_WIDTH-1:0]    wheel_set_t;

  class wheel_mix_board;
    int unsigned limit;
    wheel_set_t  wheels_q[$];
    int          errors;
    string       wheel_names[NUM_WHEELS] = '{"front-left", "front-right",
                                             "rear-right", "rear-left"};

    function new();
      limit  = LIMIT_RESET;
      errors = 0;
    endfunction

    function void set_limit(int unsigned value);
      limit = value;
    endfunction

    function int pending();
      return wheels_q.size();
    endfunction

    // clamp linear speeds, mix, then scale down to the limit if the peak exceeds it
    function void note_cmd(speed_t x_raw, speed_t y_raw, speed_t t_raw);
      longint     lim, x, y, t, peak, mag;
      longint     sum[NUM_WHEELS];
      wheel_set_t want;
      lim = limit;
      x = x_raw;
      y = y_raw;
      t = t_raw;
      if (x > lim) x = lim;
      if (x < -lim) x = -lim;
      if (y > lim) y = lim;
      if (y < -lim) y = -lim;
      sum[WHEEL_FL] =  x + y - t;
      sum[WHEEL_FR] = -x + y - t;
      sum[WHEEL_RR] = -x - y - t;
      sum[WHEEL_RL] =  x - y - t;
      peak = 0;
      for (int k = 0; k < NUM_WHEELS; k++) begin
        mag = (sum[k] < 0) ? -sum[k] : sum[k];
        if (mag > peak) peak = mag;
      end
      for (int k = 0; k < NUM_WHEELS; k++) begin
        if (peak > lim) sum[k] = (sum[k] * lim) / peak;
        want[k] = SPEED_WIDTH'(sum[k]);
      end
      wheels_q.push_back(want);
    endfunction

    function void check_wheels(wheel_set_t got);
      wheel_set_t want;
      if (wheels_q.size() == 0) begin
        errors++;
        $display("%0t: wheel transfer with nothing pending: expected none, got %0d %0d %0d %0d",
                 $time, $signed(got[WHEEL_FL]), $signed(got[WHEEL_FR]),
                 $signed(got[WHEEL_RR]), $signed(got[WHEEL_RL]));
        return;
      end
      want = wheels_q.pop_front();
      for (int k = 0; k < NUM_WHEELS; k++) begin
        if (got[k] !== want[k]) begin
          errors++;
          $display("%0t: %s speed mismatch: expected %0d, got %0d", $time,
                   wheel_names[k], $signed(want[k]), $signed(got[k]));
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  mwsm_cmd_if   cmd ();
  mwsm_wheel_if wheel ();
  mwsm_cfg_if   cfg ();

  mecanum_wheel_speed_mixer i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .wheel_o (wheel),
    .cfg_i   (cfg)
  );

  wheel_mix_board sb;
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;
  bit hold_req  = 1'b0;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  initial begin
    #3ms;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_cmd(input speed_t x, input speed_t y, input speed_t t);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 4);
    @(negedge clk_i);
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd.valid     <= 1'b1;
    cmd.x_speed   <= x;
    cmd.y_speed   <= y;
    cmd.turn_rate <= t;
    do @(posedge clk_i); while (cmd.ready !== 1'b1);
    sb.note_cmd(x, y, t);
  endtask

  // stop offering and wait out every pending wheel transfer
  task automatic drain();
    @(negedge clk_i);
    cmd.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_limit(input int unsigned value);
    drain();
    @(negedge clk_i);
    cfg.valid           <= 1'b1;
    cfg.max_wheel_speed <= LIMIT_WIDTH'(value);
    do @(posedge clk_i); while (cfg.ready !== 1'b1);
    sb.set_limit(value);
    @(negedge clk_i);
    cfg.valid <= 1'b0;
  endtask

  function automatic speed_t rand_speed(input int unsigned lim);
    int v;
    case ($urandom_range(0, 5))
      0, 1: v = int'(speed_t'($urandom));
      2: begin
        v = int'(lim) + int'($urandom_range(0, 6)) - 3;
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      3: v = int'($urandom_range(0, 2 * lim)) - int'(lim);
      4: begin
        case ($urandom_range(0, 2))
          0: v = -32768;
          1: v = 32767;
          default: v = 0;
        endcase
      end
      default: v = int'($urandom_range(0, 20)) - 10;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return speed_t'(v);
  endfunction

  initial begin : wheel_sink
    int         gap;
    wheel_set_t got;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req) begin
        gap      = LONG_HOLD;
        hold_req = 1'b0;
      end else begin
        gap = recv_calm ? 0 : $urandom_range(0, 4);
      end
      @(negedge clk_i);
      if (gap > 0) begin
        wheel.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      wheel.ready <= 1'b1;
      do @(posedge clk_i); while (wheel.valid !== 1'b1);
      got[WHEEL_FL] = wheel.front_left_speed;
      got[WHEEL_FR] = wheel.front_right_speed;
      got[WHEEL_RR] = wheel.rear_right_speed;
      got[WHEEL_RL] = wheel.rear_left_speed;
      sb.check_wheels(got);
    end
  end

  initial begin : stimulus
    int unsigned lim;
    int          a;
    speed_t      x, y, t;
    cmd.valid           = 1'b0;
    cmd.x_speed         = '0;
    cmd.y_speed         = '0;
    cmd.turn_rate       = '0;
    wheel.ready         = 1'b0;
    cfg.valid           = 1'b0;
    cfg.max_wheel_speed = '0;
    rst_ni              = 1'b0;
    sb = new();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset limit: clamps, unclamped turn, peak at and just over the limit
    send_cmd(0, 0, 0);
    send_cmd(32767, 0, 0);
    send_cmd(-32768, 0, 0);
    send_cmd(0, 32767, -32768);
    send_cmd(0, -32768, 32767);
    send_cmd(6000, 0, 0);
    send_cmd(3000, 3000, 0);
    send_cmd(3000, 3001, 0);
    send_cmd(-32768, -32768, -32768);
    send_cmd(32767, 32767, 32767);
    send_cmd(-1, 1, -1);
    send_cmd(123, -4567, 890);

    // zero limit: everything collapses to zero
    write_limit(0);
    send_cmd(0, 0, 0);
    send_cmd(5, -5, 0);
    send_cmd(0, 0, 1);
    send_cmd(32767, -32768, -32768);

    write_limit(32767);
    send_cmd(32767, 0, 0);
    send_cmd(-32768, -32768, -32768);
    send_cmd(32767, 32767, 32767);
    send_cmd(-32768, 32767, 0);

    write_limit(1);
    send_cmd(1, -1, 0);
    send_cmd(0, 0, -2);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: lim = 6000;
        1: lim = 0;
        2: lim = 32767;
        3: lim = 1;
        default: lim = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 32767)
                                                   : $urandom_range(0, 500);
      endcase
      write_limit(lim);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 40 == 0) begin
          send_calm = ($urandom_range(0, 3) == 0);
          recv_calm = ($urandom_range(0, 3) == 0);
        end
        // sink holds off long enough to back the pipeline up into cmd
        if (i == 20 && (p == 2 || p == 7)) begin
          send_calm = 1'b1;
          hold_req  = 1'b1;
        end
        if ($urandom_range(0, 7) == 0) begin
          // largest wheel sum lands exactly on the limit
          a = int'($urandom_range(0, lim));
          if ($urandom_range(0, 1) == 1) begin
            x = speed_t'(a);
            y = speed_t'(int'(lim) - a);
            t = 0;
          end else begin
            x = 0;
            y = 0;
            t = speed_t'(int'(lim));
          end
          if ($urandom_range(0, 1) == 1) begin
            x = -x;
            y = -y;
            t = -t;
          end
        end else begin
          x = rand_speed(lim);
          y = rand_speed(lim);
          t = rand_speed(lim);
        end
        send_cmd(x, y, t);
      end
    end

    drain();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/mwsm_pkg.sv
rtl/core/mwsm_cmd_if.sv
rtl/core/mwsm_wheel_if.sv
rtl/core/mwsm_cfg_if.sv
rtl/core/mwsm_div_stage.sv
rtl/core/mecanum_wheel_speed_mixer.sv
dv/tb.sv
